@@ rtl/core/ncs_pkg.sv @@
`timescale 1ns / 1ps

package ncs_pkg;

  // field widths fixed by the beat format
  localparam int BURST_W = 16;
  localparam int ARR_W   = 16;
  localparam int PRIO_W  = 8;
  localparam int PID_W   = 4;
  localparam int TIME_W  = 21;
  localparam int TOT_W   = 25;

  localparam int MAX_PROCS_DEF = 16;

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_POLICY = 1'b0;

  // policy codes
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_SJF  = 2'd1;
  localparam logic [1:0] POL_PRIO = 2'd2;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    logic [PRIO_W-1:0]  prio_value;
    logic               final_record;
  } in_t;

  typedef struct packed {
    logic [PID_W-1:0]  process_id;
    logic [TIME_W-1:0] completion;
    logic [TIME_W-1:0] waiting;
    logic [TIME_W-1:0] turnaround;
    logic [TOT_W-1:0]  total_waiting;
    logic [TOT_W-1:0]  total_turnaround;
    logic              dropped;
    logic              last_result;
  } out_t;

  // one stored process record
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [ARR_W-1:0]   arrival;
    logic [PRIO_W-1:0]  prio_value;
  } rec_t;

  // scan control into the selector
  typedef struct packed {
    logic clear;
    logic valid;
  } pick_ctl_t;

  // ordering key of a record under a policy; unused code falls back to fcfs
  function automatic logic [ARR_W-1:0] sel_key(input logic [1:0] pol, input rec_t r);
    logic [ARR_W-1:0] k;
    case (pol)
      POL_SJF:  k = r.burst;
      POL_PRIO: k = ARR_W'(r.prio_value);
      default:  k = r.arrival;
    endcase
    return k;
  endfunction

endpackage

@@ rtl/core/ncs_rec_mem.sv @@
`timescale 1ns / 1ps

module ncs_rec_mem
  import ncs_pkg::*;
#(
  parameter int DEPTH = MAX_PROCS_DEF,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  rec_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output rec_t          rdata
);

  rec_t mem [DEPTH];
  rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/ncs_pick.sv @@
`timescale 1ns / 1ps

module ncs_pick
  import ncs_pkg::*;
#(
  parameter int IDX_W = 4,
  parameter int CLK_W = 21
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       policy,
  input  pick_ctl_t        ctl,
  input  logic [IDX_W-1:0] idx,
  input  rec_t             rec,
  input  logic             done,
  input  logic [CLK_W-1:0] clock_now,
  output logic             a_found,
  output logic [IDX_W-1:0] a_idx,
  output rec_t             a_rec,
  output logic [IDX_W-1:0] e_idx,
  output rec_t             e_rec
);

  logic             a_found_r;
  logic             e_found_r;
  logic [IDX_W-1:0] a_idx_r;
  logic [IDX_W-1:0] e_idx_r;
  rec_t             a_rec_r;
  rec_t             e_rec_r;

  logic [ARR_W-1:0] key_in;
  logic [ARR_W-1:0] key_a;
  logic [ARR_W-1:0] key_e;
  logic             arrived;
  logic             take_a;
  logic             take_e;

  // best arrived entry, and earliest pending entry for an idle cpu
  always_comb begin
    key_in  = sel_key(policy, rec);
    key_a   = sel_key(policy, a_rec_r);
    key_e   = sel_key(policy, e_rec_r);
    arrived = CLK_W'(rec.arrival) <= clock_now;
    take_a  = ctl.valid && !done && arrived &&
              (!a_found_r || key_in < key_a ||
               (key_in == key_a && rec.arrival < a_rec_r.arrival));
    take_e  = ctl.valid && !done &&
              (!e_found_r || rec.arrival < e_rec_r.arrival ||
               (rec.arrival == e_rec_r.arrival && key_in < key_e));
  end

  always_ff @(posedge clk) begin
    if (take_a) begin
      a_idx_r <= idx;
      a_rec_r <= rec;
    end
    if (take_e) begin
      e_idx_r <= idx;
      e_rec_r <= rec;
    end
    if (!rst_n || ctl.clear) begin
      a_found_r <= 1'b0;
      e_found_r <= 1'b0;
    end else begin
      a_found_r <= a_found_r | take_a;
      e_found_r <= e_found_r | take_e;
    end
  end

  assign a_found = a_found_r;
  assign a_idx   = a_idx_r;
  assign a_rec   = a_rec_r;
  assign e_idx   = e_idx_r;
  assign e_rec   = e_rec_r;

endmodule

@@ rtl/core/nonpreemptive_cpu_scheduler.sv @@
`timescale 1ns / 1ps

// channel   ports                            handshake
// -------   ------------------------------   ---------------------------------
// input     start, busy, in_data             beat taken when start && !busy
// result    out_valid, out_data              one-cycle strobe, always taken
// config    psel penable pwrite paddr        write at psel&penable&pwrite&pready
//           pwdata prdata pready             pready tied high
//
// a non-final record beat is taken and busy stays low
// a final beat runs the whole schedule: each dispatch scans all n stored
// records through the one read port of the record memory, then runs a calc
// step and an emit step, with busy high throughout
// results leave one per dispatch; the receiver cannot stall them
// synchronous active-low reset empties the batch and sets policy to fcfs

module nonpreemptive_cpu_scheduler
  import ncs_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // record beats
  input  logic               start,
  output logic               busy,
  input  in_t                in_data,
  // result beats
  output logic               out_valid,
  output out_t               out_data,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  // the cpu clock never passes max arrival plus n max bursts
  localparam int CLK_W = ARR_W + CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_CALC,
    S_EMIT
  } state_t;

  // control state
  state_t           state_r,   state_nxt;
  logic [CNT_W-1:0] cnt_r,     cnt_nxt;      // stored records
  logic             ovf_r,     ovf_nxt;      // records dropped this batch
  logic [1:0]       policy_r,  policy_nxt;
  logic [CLK_W-1:0] clk_now_r, clk_now_nxt;
  logic [MAX_PROCS-1:0] done_r, done_nxt;
  logic [CNT_W-1:0] rd_cnt_r,  rd_cnt_nxt;   // scan read pointer
  logic             v1_r,      v1_nxt;       // read data valid
  logic [CNT_W-1:0] k_r,       k_nxt;        // dispatches so far
  logic [TOT_W-1:0] tot_w_r,   tot_w_nxt;
  logic [TOT_W-1:0] tot_t_r,   tot_t_nxt;
  logic             out_valid_r, out_valid_nxt;

  // payload
  logic [IDX_W-1:0] idx1_r,    idx1_nxt;
  logic [IDX_W-1:0] sel_idx_r, sel_idx_nxt;
  logic [BURST_W-1:0] sel_burst_r, sel_burst_nxt;
  logic [CLK_W-1:0] comp_r,    comp_nxt;
  logic [CLK_W-1:0] wait_r,    wait_nxt;
  out_t             out_r,     out_nxt;

  logic             acc;
  logic             cfg_wr;
  logic             mem_we;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  rec_t             mem_wdata;
  rec_t             mem_rdata;
  pick_ctl_t        pick_ctl;
  logic             pick_clear;
  logic             a_found;
  logic [IDX_W-1:0] a_idx;
  logic [IDX_W-1:0] e_idx;
  rec_t             a_rec;
  rec_t             e_rec;
  rec_t             win_rec;
  logic [IDX_W-1:0] win_idx;
  logic [CLK_W-1:0] run_start;
  logic [CLK_W-1:0] turn;
  logic             last;

  assign acc    = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_POLICY);
  assign pready = 1'b1;
  assign prdata = (paddr[PADDR_W-1:2] == REG_POLICY) ? PDATA_W'(policy_r) : '0;

  // record store, one entry per load-order id
  assign mem_we    = acc && (cnt_r < CNT_W'(MAX_PROCS));
  assign mem_wdata = '{burst: in_data.burst, arrival: in_data.arrival,
                       prio_value: in_data.prio_value};
  assign mem_re    = (state_r == S_SCAN) && (rd_cnt_r != cnt_r);
  assign mem_raddr = rd_cnt_r[IDX_W-1:0];

  ncs_rec_mem #(
    .DEPTH (MAX_PROCS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (cnt_r[IDX_W-1:0]),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign pick_ctl = '{clear: pick_clear, valid: v1_r};

  ncs_pick #(
    .IDX_W (IDX_W),
    .CLK_W (CLK_W)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .policy    (policy_r),
    .ctl       (pick_ctl),
    .idx       (idx1_r),
    .rec       (mem_rdata),
    .done      (done_r[idx1_r]),
    .clock_now (clk_now_r),
    .a_found   (a_found),
    .a_idx     (a_idx),
    .a_rec     (a_rec),
    .e_idx     (e_idx),
    .e_rec     (e_rec)
  );

  // an arrived process wins; with none arrived the cpu idles to the earliest
  assign win_rec   = a_found ? a_rec : e_rec;
  assign win_idx   = a_found ? a_idx : e_idx;
  assign run_start = a_found ? clk_now_r : CLK_W'(e_rec.arrival);
  assign turn      = wait_r + CLK_W'(sel_burst_r);
  assign last      = (CNT_W'(k_r + 1'b1) == cnt_r);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    policy_nxt    = policy_r;
    clk_now_nxt   = clk_now_r;
    done_nxt      = done_r;
    rd_cnt_nxt    = rd_cnt_r;
    v1_nxt        = mem_re;
    idx1_nxt      = mem_raddr;
    k_nxt         = k_r;
    tot_w_nxt     = tot_w_r;
    tot_t_nxt     = tot_t_r;
    out_valid_nxt = 1'b0;
    sel_idx_nxt   = sel_idx_r;
    sel_burst_nxt = sel_burst_r;
    comp_nxt      = comp_r;
    wait_nxt      = wait_r;
    out_nxt       = out_r;
    pick_clear    = 1'b0;

    if (cfg_wr) begin
      policy_nxt = pwdata[1:0];
    end

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          if (mem_we) begin
            cnt_nxt = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.final_record) begin
            state_nxt  = S_SCAN;
            rd_cnt_nxt = '0;
            k_nxt      = '0;
            pick_clear = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (mem_re) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else if (!v1_r) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        comp_nxt          = run_start + CLK_W'(win_rec.burst);
        wait_nxt          = run_start - CLK_W'(win_rec.arrival);
        clk_now_nxt       = comp_nxt;
        done_nxt[win_idx] = 1'b1;
        sel_idx_nxt       = win_idx;
        sel_burst_nxt     = win_rec.burst;
        state_nxt         = S_EMIT;
      end
      S_EMIT: begin
        tot_w_nxt     = tot_w_r + TOT_W'(wait_r);
        tot_t_nxt     = tot_t_r + TOT_W'(turn);
        out_valid_nxt = 1'b1;
        out_nxt       = '{process_id:       PID_W'(sel_idx_r),
                          completion:       TIME_W'(comp_r),
                          waiting:          TIME_W'(wait_r),
                          turnaround:       TIME_W'(turn),
                          total_waiting:    tot_w_nxt,
                          total_turnaround: tot_t_nxt,
                          dropped:          ovf_r,
                          last_result:      last};
        if (last) begin
          // batch done: empty for the next load
          state_nxt   = S_IDLE;
          cnt_nxt     = '0;
          ovf_nxt     = 1'b0;
          done_nxt    = '0;
          clk_now_nxt = '0;
          tot_w_nxt   = '0;
          tot_t_nxt   = '0;
        end else begin
          state_nxt  = S_SCAN;
          k_nxt      = k_r + 1'b1;
          rd_cnt_nxt = '0;
          pick_clear = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx1_r      <= idx1_nxt;
    sel_idx_r   <= sel_idx_nxt;
    sel_burst_r <= sel_burst_nxt;
    comp_r      <= comp_nxt;
    wait_r      <= wait_nxt;
    out_r       <= out_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      policy_r    <= POL_FCFS;
      clk_now_r   <= '0;
      done_r      <= '0;
      rd_cnt_r    <= '0;
      v1_r        <= 1'b0;
      k_r         <= '0;
      tot_w_r     <= '0;
      tot_t_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      policy_r    <= policy_nxt;
      clk_now_r   <= clk_now_nxt;
      done_r      <= done_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      v1_r        <= v1_nxt;
      k_r         <= k_nxt;
      tot_w_r     <= tot_w_nxt;
      tot_t_r     <= tot_t_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ rtl/core/ncs_checker.sv @@
`timescale 1ns / 1ps

module ncs_checker
  import ncs_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  // a plain record beat never starts a schedule
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_data.final_record) |=> !busy)
    else $error("busy after non-final record beat");

  // a final beat starts the schedule
  a_final_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.final_record) |=> busy)
    else $error("final record beat did not start schedule");

  // results are spaced apart by the scan
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("back-to-back result beats");

  // the last result releases the block, earlier ones keep it busy
  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_data.last_result))
    else $error("busy disagrees with last_result");

  // a result only follows a busy cycle
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result beat without schedule");

endmodule

bind nonpreemptive_cpu_scheduler ncs_checker u_ncs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
